// ===== rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants of the depth pixel colorizer
// Default depth window, fixed field widths and the stage records.
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int unsigned NEAR_DEPTH_DEF = 800;
	localparam int unsigned DEPTH_SPAN_DEF = 3200;

	localparam int unsigned NUM_PLAYERS = 7;
	localparam int unsigned DEPTH_W     = 13;
	localparam int unsigned DIFF_W      = 14;
	localparam int unsigned RATIO_W     = 16;
	localparam int unsigned Q_FRAC      = 14;
	localparam int unsigned CH_W        = 8;

	localparam logic [CH_W-1:0] CH_MAX = 8'hff;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_PLAYER_COLOR_1 = 3'd0,
		REG_PLAYER_COLOR_2 = 3'd1,
		REG_PLAYER_COLOR_3 = 3'd2,
		REG_PLAYER_COLOR_4 = 3'd3,
		REG_PLAYER_COLOR_5 = 3'd4,
		REG_PLAYER_COLOR_6 = 3'd5,
		REG_PLAYER_COLOR_7 = 3'd6
	} dpc_reg_t;

	// Payload that travels beside the ratio computation.
	typedef struct packed {
		logic [15:0]     word;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            scale;
	} dpc_item_t;

	// Load enables of the stages inside the ratio unit.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} dpc_adv_t;

endpackage

// ===== rtl/dpc_ratio.sv =====
// ----------------------------------------------------------------------------
// dpc_ratio: depth ratio in unsigned Q2.14
// Computes min(floor(diff * 2^14 / span), 65535) over three stages by a
// reciprocal multiply, a remainder check and a one-step correction.
// ----------------------------------------------------------------------------
module dpc_ratio import dpc_pkg::*; #(
	parameter int unsigned DEPTH_SPAN = DEPTH_SPAN_DEF
) (
	input  logic               clk,
	input  dpc_adv_t           adv,
	input  logic [DIFF_W-1:0]  diff_s1,
	output logic [RATIO_W-1:0] ratio_s4
);

	localparam int unsigned SPAN_EFF = (DEPTH_SPAN == 0) ? 1 : DEPTH_SPAN;
	localparam int unsigned RECIP_SH = 30;
	localparam int unsigned RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SH) / SPAN_EFF);
	localparam int unsigned PROD_W   = DIFF_W + RECIP_W;
	localparam int unsigned QEST_LSB = RECIP_SH - Q_FRAC;
	localparam int unsigned QEST_W   = PROD_W - QEST_LSB;
	// The remainder is below twice the span, so 15 bits hold it exactly.
	localparam int unsigned REM_W    = DEPTH_W + 2;
	localparam logic [DEPTH_W-1:0] SPAN_C = DEPTH_W'(SPAN_EFF);

	logic [PROD_W-1:0]  prod_s2;
	logic [DIFF_W-1:0]  diff_s2;
	logic [QEST_W-1:0]  qest_s3;
	logic [REM_W-1:0]   rem_s3;

	logic [QEST_W-1:0]  qest_c;
	logic [REM_W-1:0]   num_lo_c;
	logic [REM_W-1:0]   back_c;
	logic [QEST_W:0]    q_c;

	assign qest_c   = prod_s2[PROD_W-1:QEST_LSB];
	assign num_lo_c = {diff_s2[0], {Q_FRAC{1'b0}}};
	assign back_c   = REM_W'(qest_c[REM_W-1:0] * SPAN_C);
	assign q_c      = {1'b0, qest_s3} + ((rem_s3 >= REM_W'(SPAN_C)) ? 1'b1 : 1'b0);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= diff_s1 * RECIP;
			diff_s2 <= diff_s1;
		end
		if (adv.s3) begin
			qest_s3 <= qest_c;
			rem_s3  <= num_lo_c - back_c;
		end
		if (adv.s4) begin
			if (q_c > (QEST_W+1)'({RATIO_W{1'b1}})) begin
				ratio_s4 <= {RATIO_W{1'b1}};
			end else begin
				ratio_s4 <= q_c[RATIO_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/depth_pixel_colorizer.sv =====
// The result passes six register stages, s1 to s6, and leaves registered in s6.
// Throughput: one item per cycle while out_ready is high; each stage holds its
// item while the stage after it is full and stalled, so bubbles are squeezed out.
// Reset clears all stage valid bits and the seven player color registers.
// Configuration writes are always ready and take effect on the next item.
// ----------------------------------------------------------------------------
// depth_pixel_colorizer: player colors for packed depth pixels
// Passes the pixel word through and gives a gray or player color, scaled by
// a depth ratio when the player's intensity flag is set.
// ----------------------------------------------------------------------------
module depth_pixel_colorizer import dpc_pkg::*; #(
	parameter int unsigned NEAR_DEPTH = NEAR_DEPTH_DEF,
	parameter int unsigned DEPTH_SPAN = DEPTH_SPAN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] depth_word,
	output logic [2:0]  player_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha
);

	localparam int unsigned SPAN_EFF = (DEPTH_SPAN == 0) ? 1 : DEPTH_SPAN;
	localparam logic [DIFF_W-1:0] FAR_END = DIFF_W'(NEAR_DEPTH + SPAN_EFF);
	localparam int unsigned SP_W = RATIO_W + CH_W;

	logic [31:0] color_q [NUM_PLAYERS];

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	dpc_adv_t ratio_adv;

	dpc_item_t item_c, item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [DIFF_W-1:0] diff_c, diff_s1;
	logic [RATIO_W-1:0] ratio_s4;
	logic [SP_W-1:0] prod_r_s5, prod_g_s5, prod_b_s5;

	logic [DEPTH_W-1:0] depth_c;
	logic [2:0] player_c;
	logic [31:0] color_c;

	// Each stage loads when it is empty or its content moves on.
	assign adv6 = !v6_s6 || out_ready;
	assign adv5 = !v5_s5 || adv6;
	assign adv4 = !v4_s4 || adv5;
	assign adv3 = !v3_s3 || adv4;
	assign adv2 = !v2_s2 || adv3;
	assign adv1 = !v1_s1 || adv2;

	assign in_ready  = adv1;
	assign cfg_ready = 1'b1;
	assign ratio_adv = '{s2: adv2, s3: adv3, s4: adv4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLAYERS; i++) begin
				color_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PLAYER_COLOR_1: color_q[0] <= cfg_data;
				REG_PLAYER_COLOR_2: color_q[1] <= cfg_data;
				REG_PLAYER_COLOR_3: color_q[2] <= cfg_data;
				REG_PLAYER_COLOR_4: color_q[3] <= cfg_data;
				REG_PLAYER_COLOR_5: color_q[4] <= cfg_data;
				REG_PLAYER_COLOR_6: color_q[5] <= cfg_data;
				REG_PLAYER_COLOR_7: color_q[6] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign depth_c  = pixel_word[15:3];
	assign player_c = pixel_word[2:0];
	assign diff_c   = (FAR_END >= {1'b0, depth_c}) ? FAR_END - {1'b0, depth_c}
	                                               : {1'b0, depth_c} - FAR_END;

	always_comb begin
		color_c = '0;
		if (player_c != 3'd0) begin
			color_c = color_q[player_c - 3'd1];
		end
		item_c.word = pixel_word;
		if (player_c == 3'd0) begin
			// Gray is the low byte of depth >> 4.
			item_c.red   = pixel_word[14:7];
			item_c.green = pixel_word[14:7];
			item_c.blue  = pixel_word[14:7];
			item_c.scale = 1'b0;
		end else begin
			item_c.red   = color_c[7:0];
			item_c.green = color_c[15:8];
			item_c.blue  = color_c[23:16];
			item_c.scale = (color_c[31:24] != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (adv1) v1_s1 <= in_valid;
			if (adv2) v2_s2 <= v1_s1;
			if (adv3) v3_s3 <= v2_s2;
			if (adv4) v4_s4 <= v3_s3;
			if (adv5) v5_s5 <= v4_s4;
			if (adv6) v6_s6 <= v5_s5;
		end
	end

	dpc_ratio #(
		.DEPTH_SPAN (DEPTH_SPAN)
	) u_ratio (
		.clk      (clk),
		.adv      (ratio_adv),
		.diff_s1  (diff_s1),
		.ratio_s4 (ratio_s4)
	);

	function automatic logic [CH_W-1:0] sat_channel(input logic [SP_W-1:0] p);
		logic [SP_W-Q_FRAC-1:0] v;
		v = p[SP_W-1:Q_FRAC];
		return (v > (SP_W-Q_FRAC)'(CH_MAX)) ? CH_MAX : v[CH_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s1 <= item_c;
			diff_s1 <= diff_c;
		end
		if (adv2) item_s2 <= item_s1;
		if (adv3) item_s3 <= item_s2;
		if (adv4) item_s4 <= item_s3;
		if (adv5) begin
			item_s5   <= item_s4;
			prod_r_s5 <= ratio_s4 * item_s4.red;
			prod_g_s5 <= ratio_s4 * item_s4.green;
			prod_b_s5 <= ratio_s4 * item_s4.blue;
		end
		if (adv6) begin
			depth_word   <= item_s5.word;
			player_index <= item_s5.word[2:0];
			if (item_s5.scale) begin
				red   <= sat_channel(prod_r_s5);
				green <= sat_channel(prod_g_s5);
				blue  <= sat_channel(prod_b_s5);
			end else begin
				red   <= item_s5.red;
				green <= item_s5.green;
				blue  <= item_s5.blue;
			end
		end
	end

	assign out_valid = v6_s6;
	assign alpha     = CH_MAX;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the depth pixel colorizer
// Drives packed depth pixels and player color writes over valid/ready
// channels. Every item is predicted and checked in order against the output.
// A directed table covers the extremes, then random phases run under several
// color settings, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_top import dpc_pkg::*;;

	typedef struct packed {
		logic [15:0]     word;
		logic [2:0]      player;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} color_result_t;

	// Row of the directed table; stage 0 runs on the reset colors.
	typedef struct packed {
		logic            stage;
		logic [15:0]     word;
		logic            known;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} stim_row_t;

	typedef enum int {
		SET_DIRECTED,
		SET_ALL_ZERO,
		SET_ALL_ONES,
		SET_RANDOM
	} color_setting_t;

	localparam logic [2:0]  REG_UNUSED   = 3'd7;
	localparam int unsigned RATIO_MAX    = 65535;
	localparam int unsigned IDLE_PCT     = 7;
	localparam int unsigned STALL_AT     = 450;
	localparam int unsigned STALL_CYCLES = 80;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned PHASE_ITEMS  = 220;
	localparam int unsigned NUM_PHASES   = 5;
	localparam int unsigned NUM_ROWS     = 21;

	localparam logic [31:0] DIRECTED_COLORS [NUM_PLAYERS] = '{
		32'h00ffffff, 32'hffffffff, 32'h01804020, 32'h80123456,
		32'h00000000, 32'h7f0000ff, 32'h00a5c3e1
	};

	localparam color_setting_t PHASE_SETTING [NUM_PHASES] = '{
		SET_ALL_ONES, SET_ALL_ZERO, SET_RANDOM, SET_RANDOM, SET_RANDOM
	};
	localparam bit PHASE_IDLE [NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{1'b0, 16'h0000, 1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b0, 16'hfff8, 1'b1, 8'hff, 8'hff, 8'hff},
		'{1'b0, 16'h7ff8, 1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b0, 16'h8000, 1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b0, 16'h0001, 1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b0, 16'hffff, 1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b0, 16'h5554, 1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b1, 16'h0001, 1'b1, 8'hff, 8'hff, 8'hff},
		'{1'b1, 16'hfff9, 1'b1, 8'hff, 8'hff, 8'hff},
		'{1'b1, 16'h0002, 1'b1, 8'hff, 8'hff, 8'hff},
		'{1'b1, 16'h7d02, 1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b1, 16'h1902, 1'b1, 8'hff, 8'hff, 8'hff},
		'{1'b1, 16'hfffa, 1'b1, 8'hff, 8'hff, 8'hff},
		'{1'b1, 16'h1903, 1'b1, 8'h20, 8'h40, 8'h80},
		'{1'b1, 16'h4b03, 1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b1, 16'h2dac, 1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b1, 16'h1905, 1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b1, 16'h0006, 1'b1, 8'hff, 8'h00, 8'h00},
		'{1'b1, 16'habcf, 1'b1, 8'he1, 8'hc3, 8'ha5},
		'{1'b1, 16'h1e37, 1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b1, 16'h0087, 1'b0, 8'h00, 8'h00, 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] pixel_word;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] depth_word;
	logic [2:0]  player_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;

	logic [31:0]   color_reg [NUM_PLAYERS];
	color_result_t pending_colors [$];
	int unsigned   mismatches;
	int unsigned   results_seen;
	bit            idle_on;

	depth_pixel_colorizer #(
		.NEAR_DEPTH(NEAR_DEPTH_DEF),
		.DEPTH_SPAN(DEPTH_SPAN_DEF)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_word  (pixel_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.depth_word  (depth_word),
		.player_index(player_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [CH_W-1:0] scale_by_ratio(input logic [15:0] ratio,
			input logic [CH_W-1:0] ch);
		logic [23:0] prod;
		prod = ratio * ch;
		prod = prod >> Q_FRAC;
		return (prod > CH_MAX) ? CH_MAX : prod[CH_W-1:0];
	endfunction

	function automatic color_result_t colorize_pixel(input logic [15:0] w);
		color_result_t     res;
		logic [31:0]       c;
		logic [15:0]       ratio;
		longint unsigned   span;
		longint unsigned   far_end;
		longint unsigned   depth;
		longint unsigned   diff;
		longint unsigned   q;
		res.word   = w;
		res.player = w[2:0];
		res.alpha  = CH_MAX;
		if (w[2:0] == 3'd0) begin
			// Gray level is the low byte of depth >> 4.
			res.red   = w[14:7];
			res.green = w[14:7];
			res.blue  = w[14:7];
		end else begin
			c         = color_reg[w[2:0] - 3'd1];
			res.red   = c[7:0];
			res.green = c[15:8];
			res.blue  = c[23:16];
			if (c[31:24] != 8'd0) begin
				span    = (DEPTH_SPAN_DEF == 0) ? 1 : DEPTH_SPAN_DEF;
				far_end = NEAR_DEPTH_DEF + span;
				depth   = w[15:3];
				diff    = (far_end >= depth) ? far_end - depth : depth - far_end;
				q       = (diff << Q_FRAC) / span;
				ratio   = (q > RATIO_MAX) ? 16'hffff : q[15:0];
				res.red   = scale_by_ratio(ratio, res.red);
				res.green = scale_by_ratio(ratio, res.green);
				res.blue  = scale_by_ratio(ratio, res.blue);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input color_result_t want,
			input color_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected word=%h player=%0d rgba=%h %h %h %h",
				$realtime, what, want.word, want.player, want.red, want.green,
				want.blue, want.alpha);
			$display("%0t: %s:      got word=%h player=%0d rgba=%h %h %h %h",
				$realtime, what, got.word, got.player, got.red, got.green,
				got.blue, got.alpha);
		end
	endtask

	// Called at a rising edge; returns at the edge where the item is accepted,
	// with in_valid still high.
	task automatic send_pixel(input logic [15:0] w, input bit known,
			input color_result_t typed);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid   <= 1'b1;
		pixel_word <= w;
		do @(negedge clk); while (!in_ready);
		pending_colors.push_back(known ? typed : colorize_pixel(w));
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_ready);
		if (idx < NUM_PLAYERS)
			color_reg[idx] = data;
		@(posedge clk);
	endtask

	task automatic program_colors(input color_setting_t kind);
		logic [31:0] w;
		logic [7:0]  flag;
		for (int i = 0; i < NUM_PLAYERS; i++) begin
			case (kind)
				SET_DIRECTED: w = DIRECTED_COLORS[i];
				SET_ALL_ZERO: w = '0;
				SET_ALL_ONES: w = '1;
				default: begin
					case ($urandom_range(3))
						0:       flag = 8'h00;
						1:       flag = 8'h01;
						2:       flag = 8'hff;
						default: flag = 8'($urandom);
					endcase
					w = {flag, 24'($urandom)};
				end
			endcase
			write_reg(3'(i), w);
		end
		// A write past the last player register must leave the colors alone.
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output side: random idling plus one long hold-off so the pipe backs up.
	initial begin
		int unsigned hold;
		bit          stalled_once;
		hold         = 0;
		stalled_once = 1'b0;
		out_ready    = 1'b0;
		forever begin
			@(posedge clk);
			if (!stalled_once && results_seen >= STALL_AT) begin
				stalled_once = 1'b1;
				hold         = STALL_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Handshake signals are stable at the falling edge, and the item moves at
	// the next rising edge.
	always @(negedge clk) begin : watch_output
		color_result_t got;
		color_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = '{depth_word, player_index, red, green, blue, alpha};
			if (pending_colors.size() == 0) begin
				report_mismatch("result with no item pending", '0, got);
			end else begin
				want = pending_colors.pop_front();
				if (got.word !== want.word || got.player !== want.player ||
						got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.alpha !== want.alpha)
					report_mismatch("color mismatch", want, got);
			end
		end
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		stim_row_t     row;
		color_result_t typed;
		logic          cfg_stage;
		logic [12:0]   depth;
		logic [2:0]    player;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel_word   = '0;
		idle_on      = 1'b1;
		mismatches   = 0;
		results_seen = 0;
		cfg_stage    = 1'b0;
		for (int i = 0; i < NUM_PLAYERS; i++)
			color_reg[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.stage && !cfg_stage) begin
				in_valid <= 1'b0;
				wait_idle();
				program_colors(SET_DIRECTED);
				cfg_stage = 1'b1;
			end
			typed = '{row.word, row.word[2:0], row.red, row.green, row.blue, CH_MAX};
			send_pixel(row.word, row.known, typed);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			in_valid <= 1'b0;
			wait_idle();
			idle_on = PHASE_IDLE[p];
			program_colors(PHASE_SETTING[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				player = 3'($urandom_range(7));
				// Bias some depths onto the edges of the ratio window.
				case ($urandom_range(9))
					0:       depth = '0;
					1:       depth = '1;
					2:       depth = 13'(NEAR_DEPTH_DEF);
					3:       depth = 13'(NEAR_DEPTH_DEF + DEPTH_SPAN_DEF);
					default: depth = 13'($urandom);
				endcase
				send_pixel({depth, player}, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		idle_on = 1'b1;
		wait_idle();
		if (pending_colors.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
